>>> src/npc_pkg.sv
// Shared constants, codes and control types for the nearest palette color block.
package npc_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int INDEX_SPAN    = 16;
    localparam int SIZE_LIMIT    = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

    localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
    localparam int IDX_W   = 4;
    localparam int COLOR_W = 8;
    localparam int ENTRY_W = 3 * COLOR_W;
    localparam int SQ_W    = 2 * COLOR_W;
    localparam int DIST_W  = 18;
    localparam int SIZE_W  = 5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_we;
        logic             capture_pixel;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } npc_cmd_t;

endpackage

>>> src/npc_ctrl.sv
// Controller: request acceptance, palette size register and scan sequencing.
module npc_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       cmd,
    input  logic                       cfg_we,
    input  logic [npc_pkg::SIZE_W-1:0] cfg_wdata,
    output logic                       busy,
    output logic                       done,
    output npc_pkg::npc_cmd_t          dp_cmd
);
    import npc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN1 = 5'b00100,
        ST_DRAIN2 = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [SIZE_W-1:0]  size_eff;
    logic               accept;

    assign accept = start && (state_reg == ST_IDLE);

    // A size of zero scans entry zero only; large sizes stop at the last nameable entry.
    always_comb
    begin
        size_eff = size_reg;
        if (size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        if (size_reg > SIZE_W'(SIZE_LIMIT))
        begin
            size_eff = SIZE_W'(SIZE_LIMIT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_PIXEL))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    last_next  = IDX_W'(size_eff - SIZE_W'(1));
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_RESULT;
            ST_RESULT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= '0;
            size_reg  <= SIZE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESULT);

    assign dp_cmd.load_we       = accept && (cmd == CMD_LOAD);
    assign dp_cmd.capture_pixel = accept && (cmd == CMD_PIXEL);
    assign dp_cmd.rd_en         = (state_reg == ST_SCAN);
    assign dp_cmd.rd_idx        = cnt_reg;

endmodule

>>> src/npc_datapath.sv
// Datapath: palette memory, distance pipeline and running minimum.
module npc_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  npc_pkg::npc_cmd_t           dp_cmd,
    input  logic [npc_pkg::IDX_W-1:0]   entry_index,
    input  logic [npc_pkg::COLOR_W-1:0] red_in,
    input  logic [npc_pkg::COLOR_W-1:0] green_in,
    input  logic [npc_pkg::COLOR_W-1:0] blue_in,
    output logic [npc_pkg::COLOR_W-1:0] red_out,
    output logic [npc_pkg::COLOR_W-1:0] green_out,
    output logic [npc_pkg::COLOR_W-1:0] blue_out,
    output logic [npc_pkg::IDX_W-1:0]   chosen_index,
    output logic [npc_pkg::DIST_W-1:0]  best_distance
);
    import npc_pkg::*;

    logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];

    logic [ENTRY_W-1:0] pixel_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_valid_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [ENTRY_W-1:0] dist_color_reg;
    logic [IDX_W-1:0]   dist_idx_reg;
    logic               dist_valid_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [ENTRY_W-1:0] best_color_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic               wr_in_range;
    logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
    logic [DIST_W-1:0]  dist_sum;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    assign wr_in_range = (32'(entry_index) < 32'(PALETTE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_we && wr_in_range)
        begin
            palette_mem[ADDR_W'(entry_index)] <= {red_in, green_in, blue_in};
        end
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= palette_mem[ADDR_W'(dp_cmd.rd_idx)];
        end
    end

    assign sq_r = sq_diff(rd_data_reg[3*COLOR_W-1:2*COLOR_W], pixel_reg[3*COLOR_W-1:2*COLOR_W]);
    assign sq_g = sq_diff(rd_data_reg[2*COLOR_W-1:COLOR_W], pixel_reg[2*COLOR_W-1:COLOR_W]);
    assign sq_b = sq_diff(rd_data_reg[COLOR_W-1:0], pixel_reg[COLOR_W-1:0]);
    assign dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= dp_cmd.rd_en;
            dist_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture_pixel)
        begin
            pixel_reg <= {red_in, green_in, blue_in};
        end
        rd_idx_reg     <= dp_cmd.rd_idx;
        dist_reg       <= dist_sum;
        dist_color_reg <= rd_data_reg;
        dist_idx_reg   <= rd_idx_reg;

        // The all-ones start value exceeds any real distance, so entry zero always wins first.
        if (dp_cmd.capture_pixel)
        begin
            best_dist_reg <= '1;
        end
        else if (dist_valid_reg && (dist_reg < best_dist_reg))
        begin
            best_dist_reg  <= dist_reg;
            best_color_reg <= dist_color_reg;
            best_idx_reg   <= dist_idx_reg;
        end
    end

    assign red_out       = best_color_reg[3*COLOR_W-1:2*COLOR_W];
    assign green_out     = best_color_reg[2*COLOR_W-1:COLOR_W];
    assign blue_out      = best_color_reg[COLOR_W-1:0];
    assign chosen_index  = best_idx_reg;
    assign best_distance = best_dist_reg;

endmodule

>>> src/nearest_palette_color_top.sv
// Top level of the nearest palette color block: controller plus datapath.
// A load request is taken in the cycle it is presented and busy stays low after it.
// A pixel request holds busy through the scan, drain and result states; the done strobe
// marks the last of them, and a new request can be taken once busy is low again.
// The scan reads one palette entry per cycle from the memory read port.
// Reset clears the controller and sets the size to one; palette contents stay unknown.
module nearest_palette_color_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic                        cfg_we,
    input  logic [npc_pkg::SIZE_W-1:0]  cfg_wdata,
    input  logic                        cmd,
    input  logic [npc_pkg::IDX_W-1:0]   entry_index,
    input  logic [npc_pkg::COLOR_W-1:0] red_in,
    input  logic [npc_pkg::COLOR_W-1:0] green_in,
    input  logic [npc_pkg::COLOR_W-1:0] blue_in,
    output logic [npc_pkg::COLOR_W-1:0] red_out,
    output logic [npc_pkg::COLOR_W-1:0] green_out,
    output logic [npc_pkg::COLOR_W-1:0] blue_out,
    output logic [npc_pkg::IDX_W-1:0]   chosen_index,
    output logic [npc_pkg::DIST_W-1:0]  best_distance
);
    import npc_pkg::*;

    npc_cmd_t dp_cmd;

    npc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .done      (done),
        .dp_cmd    (dp_cmd)
    );

    npc_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .entry_index   (entry_index),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .chosen_index  (chosen_index),
        .best_distance (best_distance)
    );

endmodule

>>> src/npc_checker.sv
// Port-level checker for the nearest palette color block, bound to the top level.
module npc_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       done,
    input  logic                       cmd,
    input  logic [npc_pkg::DIST_W-1:0] best_distance
);
    import npc_pkg::*;

    // The result strobe comes in the last busy cycle of a pixel request.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after done");

    // A load request finishes in the cycle it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_LOAD)) |=> !busy)
        else $error("load request left block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_PIXEL)) |=> (busy && !done))
        else $error("pixel request not started");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (best_distance <= DIST_W'(195075)))
        else $error("distance out of range");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .cmd           (cmd),
    .best_distance (best_distance)
);
